// ===== rtl/core/crbr_pkg.sv =====
package crbr_pkg;

	// Access codes carried in the op field
	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_STATUS = 2'd2;
	localparam logic [1:0] OP_NOP    = 2'd3;

	// Size codes with a meaning of their own
	localparam logic [2:0] SIZE_NONE = 3'd0;
	localparam logic [2:0] SIZE_WORD = 3'd7;

	localparam logic [7:0]  GET_DATA_CMD = 8'hB7;
	localparam logic [31:0] SECURE_LIMIT = 32'h0000_8000;
	localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;

	// Fetch addresses wrap inside one page
	localparam int unsigned PAGE_BYTES = 4096;
	localparam logic [31:0] PAGE_MASK  = 32'(PAGE_BYTES - 1);

	localparam int unsigned CNT_W = 13;
	typedef logic [CNT_W-1:0] count_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [31:0] fetch_address;
		logic        busy_res;
		logic        data_ready;
		logic        done_irq;
		logic        stray_read;
		logic        spin_status;
	} result_t;

	// Words in a block for a size code: 256 << code bytes, 4 bytes a word
	function automatic count_t words_for_code(input logic [2:0] code);
		count_t n;
		case (code)
			SIZE_NONE: n = '0;
			SIZE_WORD: n = count_t'(1);
			default:   n = count_t'(13'd64 << code);
		endcase
		return n;
	endfunction

endpackage

// ===== rtl/core/crbr_in_if.sv =====
interface crbr_in_if;
	import crbr_pkg::*;

	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [7:0]  command_code;
	logic [31:0] rom_address;
	logic [2:0]  size_code;
	logic [31:0] rom_word;

	modport source (output valid, op, command_code, rom_address, size_code, rom_word,
		input ready);
	modport sink (input valid, op, command_code, rom_address, size_code, rom_word,
		output ready);
endinterface

// ===== rtl/core/crbr_out_if.sv =====
interface crbr_out_if;
	import crbr_pkg::*;

	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic [31:0] fetch_address;
	logic        busy_res;
	logic        data_ready;
	logic        done_irq;
	logic        stray_read;
	logic        spin_status;

	modport source (output valid, read_data, fetch_address, busy_res, data_ready, done_irq,
		stray_read, spin_status, input ready);
	modport sink (input valid, read_data, fetch_address, busy_res, data_ready, done_irq,
		stray_read, spin_status, output ready);
endinterface

// ===== rtl/core/card_rom_block_reader_unit.sv =====
// Each accepted item yields a registered result. Throughput: one item per
// cycle while no result waits; the block state and the result register or
// skid entry are updated in the same cycle. While a result waits, a skid
// entry takes one more item, then the input stalls until the result leaves.
// Reset (arst_n low, asynchronous): no block in flight, counters and start
// address cleared, completion interrupt disabled, output buffer empty.
module card_rom_block_reader_unit (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_data,
	crbr_in_if.sink   req,
	crbr_out_if.source rsp
);
	import crbr_pkg::*;

	logic        irq_en_q;
	logic        block_active_q;
	logic [31:0] block_start_q;
	logic        is_get_data_q;
	count_t      word_total_q;
	count_t      words_done_q;

	logic        out_valid_q;
	logic        skid_valid_q;
	result_t     out_q;
	result_t     skid_q;

	logic        accept;
	logic        load_out;
	logic        nx_active;
	logic [31:0] nx_start;
	logic        nx_get_data;
	count_t      nx_total;
	count_t      nx_done;
	count_t      done_inc;
	logic [31:0] off;
	logic        start_gd;
	result_t     res;

	assign accept   = req.valid && req.ready;
	assign req.ready = !skid_valid_q;
	assign load_out = !out_valid_q || rsp.ready;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_en_q <= 1'b0;
		end else if (cfg_we) begin
			irq_en_q <= cfg_data;
		end
	end

	// Next block state and the result of the current item
	assign done_inc = words_done_q + count_t'(1);
	assign off      = (block_start_q + {17'd0, words_done_q, 2'b00}) & PAGE_MASK;
	assign start_gd = (req.command_code == GET_DATA_CMD);

	always_comb begin
		nx_active   = block_active_q;
		nx_start    = block_start_q;
		nx_get_data = is_get_data_q;
		nx_total    = word_total_q;
		nx_done     = words_done_q;
		res.read_data     = ALL_ONES;
		res.fetch_address = '0;
		res.done_irq      = 1'b0;
		res.stray_read    = 1'b0;
		// busy and data-ready always move together, so a spin is never seen
		res.spin_status   = 1'b0;
		case (req.op)
			OP_START: begin
				nx_get_data = start_gd;
				// low get-data addresses map into the secure area window
				if (start_gd && (req.rom_address < SECURE_LIMIT)) begin
					nx_start = SECURE_LIMIT + {23'd0, req.rom_address[8:0]};
				end else begin
					nx_start = req.rom_address;
				end
				nx_total  = words_for_code(req.size_code);
				nx_done   = '0;
				nx_active = (nx_total != '0);
				if (!nx_active) begin
					res.done_irq = irq_en_q;
				end
			end
			OP_READ: begin
				if (!block_active_q) begin
					res.stray_read = 1'b1;
				end else begin
					if (is_get_data_q) begin
						res.fetch_address = (block_start_q & ~PAGE_MASK) | off;
						res.read_data     = req.rom_word;
					end
					nx_done = done_inc;
					if (done_inc == word_total_q) begin
						nx_active    = 1'b0;
						res.done_irq = irq_en_q;
					end
				end
			end
			OP_STATUS: begin
			end
			default: begin
			end
		endcase
		res.busy_res   = nx_active;
		res.data_ready = nx_active;
	end

	// Block state, updated once per accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_active_q <= 1'b0;
			block_start_q  <= '0;
			is_get_data_q  <= 1'b0;
			word_total_q   <= '0;
			words_done_q   <= '0;
		end else if (accept) begin
			block_active_q <= nx_active;
			block_start_q  <= nx_start;
			is_get_data_q  <= nx_get_data;
			word_total_q   <= nx_total;
			words_done_q   <= nx_done;
		end
	end

	// Output buffer control: result register plus skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_out) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= accept;
			end else begin
				out_valid_q  <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Output buffer payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			if (skid_valid_q) begin
				out_q  <= skid_q;
				skid_q <= res;
			end else begin
				out_q  <= res;
			end
		end else if (accept) begin
			skid_q <= res;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.read_data     = out_q.read_data;
	assign rsp.fetch_address = out_q.fetch_address;
	assign rsp.busy_res      = out_q.busy_res;
	assign rsp.data_ready    = out_q.data_ready;
	assign rsp.done_irq      = out_q.done_irq;
	assign rsp.stray_read    = out_q.stray_read;
	assign rsp.spin_status   = out_q.spin_status;

`ifndef SYNTHESIS
	// skid entry is only filled behind a waiting result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid with empty result register");

	// an active block never has all its words done
	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		block_active_q |-> (words_done_q < word_total_q))
		else $error("word count reached total with block active");

	// a stray read hands out nothing
	a_stray_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.stray_read) |->
		(out_q.read_data == ALL_ONES && out_q.fetch_address == '0))
		else $error("stray read returned data");

	// the completion interrupt comes only with busy dropped
	a_irq_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.done_irq) |-> !out_q.busy_res)
		else $error("completion interrupt with block still busy");
`endif

endmodule

// ===== tb/card_rom_block_reader_unit_test.sv =====
`timescale 1ns / 1ps

module card_rom_block_reader_unit_test;
	import crbr_pkg::*;

	localparam int unsigned HALF_PERIOD = 2;
	localparam int unsigned RESET_CYCLES = 12;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned STALL_LIMIT = 3000;
	localparam logic [31:0] SECURE_LOW_MASK = 32'h0000_01FF;

	// One bus access toward the cartridge
	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  command_code;
		logic [31:0] rom_address;
		logic [2:0]  size_code;
		logic [31:0] rom_word;
	} card_access_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_data;

	crbr_in_if  access_ch ();
	crbr_out_if result_ch ();

	card_rom_block_reader_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.req      (access_ch),
		.rsp      (result_ch)
	);

	card_access_t pending_accesses[$];
	result_t      expected_results[$];

	// Cartridge model state
	logic        irq_en_model;
	logic        blk_active;
	logic [31:0] blk_base;
	logic        blk_get_data;
	count_t      blk_words;
	count_t      blk_count;

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned hold_asked;
	int unsigned hold_served;
	int unsigned hold_left;
	int unsigned stall_cycles;
	int unsigned mismatch_count;
	logic        access_taken;

	always #HALF_PERIOD clk = ~clk;

	// Bus-visible effect of one access; advances the cartridge model
	function automatic result_t predict_card_access(input card_access_t a);
		result_t     r;
		logic [31:0] start_addr;
		logic [31:0] offs;
		r.read_data     = ALL_ONES;
		r.fetch_address = '0;
		r.done_irq      = 1'b0;
		r.stray_read    = 1'b0;
		r.spin_status   = 1'b0;
		case (a.op)
			OP_START: begin
				blk_get_data = (a.command_code == GET_DATA_CMD);
				start_addr = a.rom_address;
				// secure area is redirected for get-data
				if (blk_get_data && start_addr < SECURE_LIMIT)
					start_addr = SECURE_LIMIT + (start_addr & SECURE_LOW_MASK);
				blk_base = start_addr;
				case (a.size_code)
					SIZE_NONE: blk_words = '0;
					SIZE_WORD: blk_words = count_t'(1);
					default:   blk_words = count_t'((32'd256 << a.size_code) >> 2);
				endcase
				blk_count = '0;
				blk_active = (blk_words != '0);
				if (!blk_active)
					r.done_irq = irq_en_model;
			end
			OP_READ: begin
				if (!blk_active) begin
					r.stray_read = 1'b1;
				end else begin
					if (blk_get_data) begin
						offs = (blk_base + (32'(blk_count) << 2)) & PAGE_MASK;
						r.fetch_address = (blk_base & ~PAGE_MASK) | offs;
						r.read_data = a.rom_word;
					end
					blk_count = blk_count + count_t'(1);
					if (blk_count == blk_words) begin
						blk_active = 1'b0;
						r.done_irq = irq_en_model;
					end
				end
			end
			default: ;
		endcase
		r.busy_res   = blk_active;
		r.data_ready = blk_active;
		return r;
	endfunction

	task automatic push_access(input logic [1:0] op, input logic [7:0] cmd,
		input logic [31:0] addr, input logic [2:0] size, input logic [31:0] word);
		card_access_t a;
		a.op = op;
		a.command_code = cmd;
		a.rom_address = addr;
		a.size_code = size;
		a.rom_word = word;
		pending_accesses.push_back(a);
	endtask

	// Mostly complete or abandoned block reads, some noise in between
	task automatic queue_random_traffic(input int unsigned n_items);
		int unsigned queued;
		int unsigned n_reads;
		int unsigned total_words;
		logic [2:0]  code;
		logic [7:0]  cmd;
		logic [31:0] addr;
		queued = 0;
		while (queued < n_items) begin
			if ($urandom_range(99) < 12) begin
				push_access(2'($urandom), 8'($urandom), $urandom, 3'($urandom), $urandom);
				queued++;
			end else begin
				case ($urandom_range(9))
					0:          code = SIZE_NONE;
					1, 2, 3, 4: code = SIZE_WORD;
					5, 6:       code = 3'd1;
					default:    code = 3'($urandom_range(6, 2));
				endcase
				cmd = ($urandom_range(4) == 0) ? 8'($urandom) : GET_DATA_CMD;
				case ($urandom_range(3))
					0:       addr = 32'($urandom_range(32'h7FFF));
					1:       addr = $urandom | 32'h0000_0FE0;
					default: addr = $urandom;
				endcase
				total_words = (code == SIZE_NONE) ? 0 : (code == SIZE_WORD) ? 1 : (64 << code);
				if (total_words <= 128 && $urandom_range(3) != 0)
					n_reads = total_words;
				else
					n_reads = $urandom_range(8);
				push_access(OP_START, cmd, addr, code, $urandom);
				queued++;
				for (int unsigned i = 0; i < n_reads; i++) begin
					if ($urandom_range(15) == 0) begin
						push_access(OP_STATUS, 8'($urandom), $urandom, 3'($urandom), $urandom);
						queued++;
					end
					push_access(OP_READ, 8'($urandom), $urandom, 3'($urandom), $urandom);
					queued++;
				end
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_accesses.size() != 0 || access_ch.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_irq_enable(input logic en);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_data = en;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Known values on every input from time zero
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = 1'b0;
		access_ch.valid = 1'b0;
		access_ch.op = OP_NOP;
		access_ch.command_code = '0;
		access_ch.rom_address = '0;
		access_ch.size_code = SIZE_NONE;
		access_ch.rom_word = '0;
		result_ch.ready = 1'b0;
		access_taken = 1'b0;
		irq_en_model = 1'b0;
		blk_active = 1'b0;
		blk_base = '0;
		blk_get_data = 1'b0;
		blk_words = '0;
		blk_count = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_asked = 0;
		hold_served = 0;
		hold_left = 0;
		stall_cycles = 0;
		mismatch_count = 0;
	end

	// Sequence of phases
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_irq_enable(1'b1);
		// stray, status and unused op with nothing in flight
		push_access(OP_READ, 8'h00, 32'h0000_0000, SIZE_NONE, 32'hFFFF_FFFF);
		push_access(OP_STATUS, 8'h00, 32'h0000_0000, SIZE_NONE, 32'h0000_0000);
		push_access(OP_NOP, 8'hFF, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF);
		// low get-data addresses land in the secure window, a high one does not
		push_access(OP_START, GET_DATA_CMD, 32'h0000_1234, SIZE_WORD, 32'h0000_0000);
		push_access(OP_READ, 8'hFF, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF);
		push_access(OP_START, GET_DATA_CMD, 32'h0000_7FFF, SIZE_WORD, 32'hFFFF_FFFF);
		push_access(OP_READ, 8'h00, 32'h0000_0000, SIZE_NONE, 32'h0000_0000);
		push_access(OP_START, GET_DATA_CMD, 32'hFFFF_FFFC, SIZE_WORD, 32'h0000_0000);
		push_access(OP_READ, 8'h00, 32'h0000_0000, SIZE_NONE, 32'hA5A5_5A5A);
		// foreign command reads all ones and is not remapped
		push_access(OP_START, 8'h00, 32'h0000_0000, SIZE_WORD, 32'h0000_0000);
		push_access(OP_READ, 8'h00, 32'h0000_0000, SIZE_NONE, 32'h1234_5678);
		// empty block ends on its start
		push_access(OP_START, GET_DATA_CMD, 32'h0000_8000, SIZE_NONE, 32'h0000_0000);
		// largest block starting near a page end wraps inside the page
		push_access(OP_START, GET_DATA_CMD, 32'h00FF_0FF8, 3'd6, 32'h0000_0000);
		for (int i = 0; i < 4; i++)
			push_access(OP_READ, 8'h00, 32'h0000_0000, SIZE_NONE, $urandom);
		push_access(OP_STATUS, 8'h00, 32'h0000_0000, SIZE_NONE, 32'h0000_0000);
		// restart while in flight drops the old block
		push_access(OP_START, 8'hFF, 32'h0000_0100, 3'd1, 32'h0000_0000);
		push_access(OP_READ, 8'h00, 32'h0000_0000, SIZE_NONE, 32'hFFFF_FFFF);
		push_access(OP_START, GET_DATA_CMD, 32'h0001_0000, SIZE_WORD, 32'h0000_0000);
		push_access(OP_READ, 8'h00, 32'h0000_0000, SIZE_NONE, 32'h0F0F_F0F0);
		push_access(OP_READ, 8'h00, 32'h0000_0000, SIZE_NONE, 32'hF0F0_0F0F);
		wait_drained();

		write_irq_enable(1'b0);
		send_idle_pct = 21;
		recv_idle_pct = 56;
		queue_random_traffic(240);
		wait_drained();

		// receiver stops for a long while so the input backs up
		write_irq_enable(1'b1);
		send_idle_pct = 56;
		recv_idle_pct = 21;
		queue_random_traffic(240);
		hold_asked++;
		wait_drained();

		write_irq_enable(1'b0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_traffic(240);
		wait_drained();

		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Access driver
	always @(negedge clk) begin
		if (!access_ch.valid || access_taken) begin
			if (arst_n && pending_accesses.size() != 0 &&
				$urandom_range(99) >= send_idle_pct) begin
				card_access_t a;
				a = pending_accesses.pop_front();
				access_ch.valid <= 1'b1;
				access_ch.op <= a.op;
				access_ch.command_code <= a.command_code;
				access_ch.rom_address <= a.rom_address;
				access_ch.size_code <= a.size_code;
				access_ch.rom_word <= a.rom_word;
			end else begin
				access_ch.valid <= 1'b0;
			end
		end
	end

	// Result ready, with random gaps and the long hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_ch.ready <= 1'b0;
		end else if (hold_asked != hold_served) begin
			hold_served <= hold_asked;
			hold_left <= HOLD_CYCLES;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Monitor: check results, predict accepted accesses, watchdog
	always @(posedge clk) begin
		result_t want;
		access_taken <= access_ch.valid && access_ch.ready;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: read_data %h", result_ch.read_data);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					if (result_ch.read_data !== want.read_data) begin
						$error("read_data: expected %h, got %h", want.read_data,
							result_ch.read_data);
						mismatch_count++;
					end
					if (result_ch.fetch_address !== want.fetch_address) begin
						$error("fetch_address: expected %h, got %h", want.fetch_address,
							result_ch.fetch_address);
						mismatch_count++;
					end
					if (result_ch.busy_res !== want.busy_res) begin
						$error("busy_res: expected %b, got %b", want.busy_res,
							result_ch.busy_res);
						mismatch_count++;
					end
					if (result_ch.data_ready !== want.data_ready) begin
						$error("data_ready: expected %b, got %b", want.data_ready,
							result_ch.data_ready);
						mismatch_count++;
					end
					if (result_ch.done_irq !== want.done_irq) begin
						$error("done_irq: expected %b, got %b", want.done_irq,
							result_ch.done_irq);
						mismatch_count++;
					end
					if (result_ch.stray_read !== want.stray_read) begin
						$error("stray_read: expected %b, got %b", want.stray_read,
							result_ch.stray_read);
						mismatch_count++;
					end
					if (result_ch.spin_status !== want.spin_status) begin
						$error("spin_status: expected %b, got %b", want.spin_status,
							result_ch.spin_status);
						mismatch_count++;
					end
				end
			end
			if (cfg_we)
				irq_en_model = cfg_data;
			if (access_ch.valid && access_ch.ready)
				expected_results.push_back(predict_card_access({access_ch.op,
					access_ch.command_code, access_ch.rom_address, access_ch.size_code,
					access_ch.rom_word}));
			// no progress on either side for too long
			if ((access_ch.valid && access_ch.ready) || (result_ch.valid && result_ch.ready)
				|| cfg_we)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

endmodule
